// ----- rtl/hrsp_pkg.sv -----
package hrsp_pkg;

   // width of the content length and body counter
   localparam int LENGTH_BITS = 31;

   // characters the parser reacts to
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // lengths of the matched words
   localparam logic [3:0] KEY_LEN  = 4'd14;
   localparam logic [2:0] POST_LEN = 3'd4;

   // byte labels
   typedef enum logic [2:0] {
      CLS_DELIM,
      CLS_METHOD,
      CLS_URI,
      CLS_VERSION,
      CLS_HNAME,
      CLS_HVALUE,
      CLS_BODY,
      CLS_ERROR
   } class_type;

   // sticky error codes
   typedef enum logic [2:0] {
      ST_OK,
      ST_METHOD,
      ST_URI,
      ST_VERSION,
      ST_HEADER,
      ST_LENGTH
   } status_type;

   // one result transfer
   typedef struct packed {
      logic [7:0]             out_byte;
      class_type              byte_class;
      logic                   request_done;
      logic                   is_post;
      logic [LENGTH_BITS-1:0] content_length;
      status_type             status;
      logic                   run_last;
   } res_type;

   // header name that carries the body length
   function automatic logic [7:0] key_char(logic [3:0] pos);
      logic [7:0] c;
      case (pos)
         4'd0:    c = "C";
         4'd1:    c = "o";
         4'd2:    c = "n";
         4'd3:    c = "t";
         4'd4:    c = "e";
         4'd5:    c = "n";
         4'd6:    c = "t";
         4'd7:    c = "-";
         4'd8:    c = "L";
         4'd9:    c = "e";
         4'd10:   c = "n";
         4'd11:   c = "g";
         4'd12:   c = "t";
         4'd13:   c = "h";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // method that allows a body
   function automatic logic [7:0] post_char(logic [1:0] pos);
      logic [7:0] c;
      case (pos)
         2'd0:    c = "P";
         2'd1:    c = "O";
         2'd2:    c = "S";
         2'd3:    c = "T";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ----- rtl/http_request_stream_parser.sv -----
// channel   ports                                  direction
// req       req_valid req_stall req_data_byte      byte stream in
//           req_new_connection
// rsp       rsp_valid rsp_stall rsp_out_byte       labelled bytes out
//           rsp_byte_class rsp_request_done rsp_is_post
//           rsp_content_length rsp_status rsp_run_last
//
// One byte is taken per cycle while req_stall is low; its results go to the output queue.
// A byte gives zero, one or two results; a held CR comes out with the following byte.
// Results sit in a three-entry output queue; req_stall is high while it holds two or more.
// Synchronous reset puts the parser at the start of a request line and empties the queue.
module http_request_stream_parser (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_data_byte,
   input  logic                             req_new_connection,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_out_byte,
   output logic [2:0]                       rsp_byte_class,
   output logic                             rsp_request_done,
   output logic                             rsp_is_post,
   output logic [hrsp_pkg::LENGTH_BITS-1:0] rsp_content_length,
   output logic [2:0]                       rsp_status,
   output logic                             rsp_run_last
);
   import hrsp_pkg::*;

   typedef enum logic [3:0] {
      PH_METHOD,
      PH_URI,
      PH_VERSION,
      PH_LSTART,
      PH_HNAME,
      PH_HSKIP,
      PH_HVALUE,
      PH_BODY,
      PH_ERROR
   } phase_type;

   typedef struct packed {
      phase_type              phase;
      logic                   cr_pending;
      logic                   token_nonempty;
      logic [2:0]             method_match_pos;
      logic                   method_is_post;
      logic [3:0]             key_match_pos;
      logic                   key_matching;
      logic                   length_seen;
      logic                   length_bad;
      logic [LENGTH_BITS-1:0] length_value;
      logic [LENGTH_BITS-1:0] body_remaining;
      status_type             error_code;
   } st_type;

   typedef struct packed {
      st_type  s;
      res_type r;
   } ord_type;

   typedef struct packed {
      st_type  s;
      res_type r0;
      res_type r1;
   } le_type;

   function automatic st_type reset_state();
      st_type s;
      s.phase            = PH_METHOD;
      s.cr_pending       = 1'b0;
      s.token_nonempty   = 1'b0;
      s.method_match_pos = '0;
      s.method_is_post   = 1'b1;
      s.key_match_pos    = '0;
      s.key_matching     = 1'b1;
      s.length_seen      = 1'b0;
      s.length_bad       = 1'b0;
      s.length_value     = '0;
      s.body_remaining   = '0;
      s.error_code       = ST_OK;
      return s;
   endfunction

   // build one result from the state at the time it is produced
   function automatic res_type make_res(st_type s, logic [7:0] b, class_type c,
                                        logic done, logic show);
      res_type                r;
      logic [LENGTH_BITS-1:0] eff;
      eff = (s.method_is_post && s.length_seen && !s.length_bad) ? s.length_value : '0;
      r.out_byte       = b;
      r.byte_class     = c;
      r.request_done   = done;
      r.is_post        = done && s.method_is_post;
      r.content_length = (show || done) ? eff : '0;
      r.status         = s.error_code;
      r.run_last       = 1'b0;
      return r;
   endfunction

   // one byte that is not a line end
   function automatic ord_type ordinary(st_type s_in, logic [7:0] b);
      ord_type                o;
      st_type                 s;
      logic                   hit;
      logic [LENGTH_BITS+3:0] v;
      s   = s_in;
      hit = 1'b0;
      v   = '0;
      o.r = make_res(s, b, CLS_ERROR, 1'b0, 1'b0);
      case (s.phase)
         PH_BODY: begin
            if (s.body_remaining != '0) begin
               s.body_remaining = s.body_remaining - 1'b1;
            end
            if (s.body_remaining == '0) begin
               o.r = make_res(s, b, CLS_BODY, 1'b1, 1'b1);
               s   = reset_state();
            end else begin
               o.r = make_res(s, b, CLS_BODY, 1'b0, 1'b0);
            end
         end
         PH_METHOD: begin
            if (b == CH_SPACE) begin
               if (!s.token_nonempty) begin
                  s.error_code = ST_METHOD;
                  s.phase      = PH_ERROR;
                  o.r          = make_res(s, b, CLS_ERROR, 1'b0, 1'b0);
               end else begin
                  s.method_is_post = s.method_is_post && (s.method_match_pos == POST_LEN);
                  s.phase          = PH_URI;
                  s.token_nonempty = 1'b0;
                  o.r              = make_res(s, b, CLS_DELIM, 1'b0, 1'b0);
               end
            end else begin
               s.token_nonempty = 1'b1;
               if (s.method_is_post && s.method_match_pos < POST_LEN &&
                   b == post_char(s.method_match_pos[1:0])) begin
                  s.method_match_pos = s.method_match_pos + 1'b1;
               end else begin
                  s.method_is_post = 1'b0;
               end
               o.r = make_res(s, b, CLS_METHOD, 1'b0, 1'b0);
            end
         end
         PH_URI: begin
            if (b == CH_SPACE) begin
               if (!s.token_nonempty) begin
                  s.error_code = ST_URI;
                  s.phase      = PH_ERROR;
                  o.r          = make_res(s, b, CLS_ERROR, 1'b0, 1'b0);
               end else begin
                  s.phase          = PH_VERSION;
                  s.token_nonempty = 1'b0;
                  o.r              = make_res(s, b, CLS_DELIM, 1'b0, 1'b0);
               end
            end else begin
               s.token_nonempty = 1'b1;
               o.r              = make_res(s, b, CLS_URI, 1'b0, 1'b0);
            end
         end
         PH_VERSION: begin
            s.token_nonempty = 1'b1;
            o.r              = make_res(s, b, CLS_VERSION, 1'b0, 1'b0);
         end
         PH_LSTART, PH_HNAME: begin
            if (s.phase == PH_LSTART) begin
               s.key_match_pos = '0;
               s.key_matching  = 1'b1;
               s.phase         = PH_HNAME;
            end
            if (b == CH_COLON) begin
               hit            = s.key_matching && (s.key_match_pos == KEY_LEN);
               s.key_matching = hit && !s.length_seen;
               if (s.key_matching) begin
                  s.length_seen = 1'b1;
               end
               s.token_nonempty = 1'b0;
               s.phase          = PH_HSKIP;
               o.r              = make_res(s, b, CLS_DELIM, 1'b0, 1'b0);
            end else begin
               if (s.key_matching && s.key_match_pos < KEY_LEN &&
                   b == key_char(s.key_match_pos)) begin
                  s.key_match_pos = s.key_match_pos + 1'b1;
               end else begin
                  s.key_matching = 1'b0;
               end
               o.r = make_res(s, b, CLS_HNAME, 1'b0, 1'b0);
            end
         end
         PH_HSKIP: begin
            s.phase = PH_HVALUE;
            o.r     = make_res(s, b, CLS_DELIM, 1'b0, 1'b0);
         end
         PH_HVALUE: begin
            s.token_nonempty = 1'b1;
            if (s.key_matching && b != CH_DASH) begin
               if (b >= CH_ZERO && b <= CH_NINE) begin
                  if (!s.length_bad) begin
                     // times ten as two shifts, plus the digit
                     v = ({4'b0, s.length_value} << 3) + ({4'b0, s.length_value} << 1) +
                         {{LENGTH_BITS{1'b0}}, b[3:0]};
                     if (v[LENGTH_BITS+3:LENGTH_BITS] != 4'b0) begin
                        s.length_bad = 1'b1;
                     end else begin
                        s.length_value = v[LENGTH_BITS-1:0];
                     end
                  end
               end else begin
                  s.length_bad = 1'b1;
               end
            end
            o.r = make_res(s, b, CLS_HVALUE, 1'b0, 1'b0);
         end
         default: begin
            o.r = make_res(s, b, CLS_ERROR, 1'b0, 1'b0);
         end
      endcase
      o.s = s;
      return o;
   endfunction

   // a CR followed by LF
   function automatic le_type line_end(st_type s_in);
      le_type     l;
      st_type     s;
      class_type  c;
      logic       done;
      logic       show;
      logic       clear;
      s     = s_in;
      c     = CLS_DELIM;
      done  = 1'b0;
      show  = 1'b0;
      clear = 1'b0;
      case (s.phase)
         PH_METHOD: begin
            s.error_code = ST_METHOD;
            s.phase      = PH_ERROR;
            c            = CLS_ERROR;
         end
         PH_URI: begin
            s.error_code = ST_URI;
            s.phase      = PH_ERROR;
            c            = CLS_ERROR;
         end
         PH_VERSION: begin
            if (!s.token_nonempty) begin
               s.error_code = ST_VERSION;
               s.phase      = PH_ERROR;
               c            = CLS_ERROR;
            end else begin
               s.phase = PH_LSTART;
            end
         end
         PH_LSTART: begin
            // blank line: body, length error or end of request
            if (s.method_is_post && s.length_seen && s.length_bad) begin
               s.error_code = ST_LENGTH;
               s.phase      = PH_ERROR;
               c            = CLS_ERROR;
            end else if (s.method_is_post && s.length_seen && s.length_value != '0) begin
               s.body_remaining = s.length_value;
               s.phase          = PH_BODY;
               show             = 1'b1;
            end else begin
               show  = 1'b1;
               done  = 1'b1;
               clear = 1'b1;
            end
         end
         PH_HNAME: begin
            s.error_code = ST_HEADER;
            s.phase      = PH_ERROR;
            c            = CLS_ERROR;
         end
         default: begin
            if (s.key_matching && !s.token_nonempty) begin
               s.length_bad = 1'b1;
            end
            s.phase = PH_LSTART;
         end
      endcase
      l.r0 = make_res(s, CH_CR, c, 1'b0, show);
      l.r1 = make_res(s, CH_LF, c, done, show);
      l.s  = clear ? reset_state() : s;
      return l;
   endfunction

   st_type     st_ff, st_in;
   st_type     s0, s_cr, mid;
   ord_type    o_cr, o_byte;
   le_type     le;
   res_type    res [2];
   logic [1:0] n_res;
   res_type    q_ff [3];
   res_type    q_in [3];
   res_type    q_sh [3];
   logic [1:0] cnt_ff, cnt_in, cnt_pop;
   logic       acc, pop;

   assign acc       = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;
   assign req_stall = (cnt_ff > 2'd1);
   assign rsp_valid = (cnt_ff != 2'd0);

   // per-byte parse step
   always_comb begin
      s0          = req_new_connection ? reset_state() : st_ff;
      s_cr        = s0;
      s_cr.cr_pending = 1'b0;
      le          = line_end(s_cr);
      o_cr        = ordinary(s_cr, CH_CR);
      mid         = s0.cr_pending ? o_cr.s : s0;
      o_byte      = ordinary(mid, req_data_byte);
      res[0]      = o_byte.r;
      res[1]      = o_byte.r;
      n_res       = 2'd0;
      st_in       = mid;
      if (s0.cr_pending && req_data_byte == CH_LF) begin
         st_in  = le.s;
         res[0] = le.r0;
         res[1] = le.r1;
         n_res  = 2'd2;
      end else begin
         if (s0.cr_pending) begin
            res[0] = o_cr.r;
            n_res  = 2'd1;
         end
         if (mid.phase != PH_BODY && mid.phase != PH_ERROR && req_data_byte == CH_CR) begin
            st_in            = mid;
            st_in.cr_pending = 1'b1;
         end else begin
            st_in = o_byte.s;
            if (n_res == 2'd1) begin
               res[1] = o_byte.r;
            end else begin
               res[0] = o_byte.r;
            end
            n_res = n_res + 2'd1;
         end
      end
      // mark the last result of this byte
      if (n_res == 2'd1) begin
         res[0].run_last = 1'b1;
      end else if (n_res == 2'd2) begin
         res[1].run_last = 1'b1;
      end
   end

   // output queue: drop the head on transfer, then append new results
   always_comb begin
      cnt_pop = cnt_ff - {1'b0, pop};
      q_sh[0] = pop ? q_ff[1] : q_ff[0];
      q_sh[1] = pop ? q_ff[2] : q_ff[1];
      q_sh[2] = q_ff[2];
      for (int i = 0; i < 3; i++) begin
         q_in[i] = q_sh[i];
         if (acc && i >= int'(cnt_pop) && i < int'(cnt_pop) + int'(n_res)) begin
            q_in[i] = res[1'(i - int'(cnt_pop))];
         end
      end
      cnt_in = cnt_pop + (acc ? n_res : 2'd0);
   end

   // state and queue registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= reset_state();
         cnt_ff <= 2'd0;
      end else begin
         if (acc) begin
            st_ff <= st_in;
         end
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
   end

   assign rsp_out_byte       = q_ff[0].out_byte;
   assign rsp_byte_class     = q_ff[0].byte_class;
   assign rsp_request_done   = q_ff[0].request_done;
   assign rsp_is_post        = q_ff[0].is_post;
   assign rsp_content_length = q_ff[0].content_length;
   assign rsp_status         = q_ff[0].status;
   assign rsp_run_last       = q_ff[0].run_last;

endmodule
